/* sv/plbu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbu_pkg
// Shared constants, codes and payload types of the price level book update.
// ----------------------------------------------------------------------------
package plbu_pkg;

  localparam int LEVELS      = 4096;
  localparam int QTY_WIDTH   = 48;
  localparam int PRICE_W     = 40;
  localparam int IN_QTY_W    = 48;
  localparam int CNT_OUT_W   = 13;
  localparam int IDX_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W       = $clog2(LEVELS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = $clog2(QUEUE_DEPTH);
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 4;
  localparam logic [PRICE_W-1:0] LOWEST_RESET  = PRICE_W'(0);
  localparam logic [PRICE_W-1:0] HIGHEST_RESET = PRICE_W'(4095);

  localparam logic [1:0] SIDE_BID = 2'd0;
  localparam logic [1:0] SIDE_ASK = 2'd1;

  // register select is the 8-byte word address bit
  localparam logic REG_LOWEST  = 1'b0;
  localparam logic REG_HIGHEST = 1'b1;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_RANGE   = 2'd1,
    ST_SIDE    = 2'd2
  } plbu_status_t;

  typedef struct packed {
    logic [1:0]          book_side;
    logic [PRICE_W-1:0]  price_tick;
    logic [IN_QTY_W-1:0] level_quantity;
  } plbu_in_t;

  typedef struct packed {
    logic [1:0]           update_status;
    logic [CNT_OUT_W-1:0] bid_levels_used;
    logic [CNT_OUT_W-1:0] ask_levels_used;
    logic                 book_empty;
  } plbu_out_t;

  // classified command handed from front to back
  typedef struct packed {
    plbu_status_t         status;
    logic                 ask;
    logic [IDX_W-1:0]     idx;
    logic [QTY_WIDTH-1:0] qty;
  } plbu_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } plbu_qstat_t;

  localparam int CMP_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

  function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] ce;
    ce = CMP_W'(c);
    if (ce > CMP_W'({CNT_OUT_W{1'b1}})) begin
      return {CNT_OUT_W{1'b1}};
    end
    return CNT_OUT_W'(ce);
  endfunction

endpackage

/* sv/plbu_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbu_front
// Classifies an incoming update: range check, level index and side decode.
// ----------------------------------------------------------------------------
module plbu_front (
  input  logic                          accept,
  input  plbu_pkg::plbu_in_t            item,
  input  logic [plbu_pkg::PRICE_W-1:0]  lowest_price_tick,
  input  logic [plbu_pkg::PRICE_W-1:0]  highest_price_tick,
  output logic                          push,
  output plbu_pkg::plbu_cmd_t           cmd
);
  import plbu_pkg::*;

  logic [PRICE_W-1:0] diff;
  logic               out_of_range;
  logic               side_known;

  assign diff         = item.price_tick - lowest_price_tick;
  assign out_of_range = (item.price_tick < lowest_price_tick) ||
                        (item.price_tick > highest_price_tick) ||
                        (diff >= PRICE_W'(LEVELS));
  assign side_known   = (item.book_side == SIDE_BID) || (item.book_side == SIDE_ASK);

  always_comb begin
    cmd.idx = diff[IDX_W-1:0];
    cmd.qty = QTY_WIDTH'(item.level_quantity);
    cmd.ask = (item.book_side == SIDE_ASK);
    // range check wins over an unknown side
    priority if (out_of_range) begin
      cmd.status = ST_RANGE;
    end else if (!side_known) begin
      cmd.status = ST_SIDE;
    end else begin
      cmd.status = ST_APPLIED;
    end
  end

  assign push = accept;

endmodule

/* sv/plbu_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbu_queue
// Short command queue between the classifying front and the store back end.
// ----------------------------------------------------------------------------
module plbu_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  plbu_pkg::plbu_cmd_t  push_cmd,
  input  logic                 pop,
  output plbu_pkg::plbu_cmd_t  head,
  output plbu_pkg::plbu_qstat_t stat
);
  import plbu_pkg::*;

  plbu_cmd_t         entries [QUEUE_DEPTH];
  logic [QA_W-1:0]   wr_ptr;
  logic [QA_W-1:0]   rd_ptr;
  logic [QA_W:0]     fill;

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == (QA_W+1)'(QUEUE_DEPTH));
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (QA_W+1)'(1);
        2'b01:   fill <= fill - (QA_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full && !pop)) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty)) else $error("queue pop while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QA_W+1)'(QUEUE_DEPTH)) else $error("queue fill overrun");

endmodule

/* sv/plbu_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbu_back
// Level stores and counters: read, compare with zero, write, count, report.
// ----------------------------------------------------------------------------
module plbu_back (
  input  logic                  clk,
  input  logic                  rst,
  input  plbu_pkg::plbu_cmd_t   head,
  input  plbu_pkg::plbu_qstat_t qstat,
  output logic                  pop,
  output logic                  clearing,
  output logic                  done,
  output plbu_pkg::plbu_out_t   result
);
  import plbu_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     clr_idx;
  plbu_cmd_t            cur;
  logic [CNT_W-1:0]     bid_cnt;
  logic [CNT_W-1:0]     ask_cnt;
  logic [CNT_W-1:0]     bid_cnt_next;
  logic [CNT_W-1:0]     ask_cnt_next;

  logic [QTY_WIDTH-1:0] bid_mem [LEVELS];
  logic [QTY_WIDTH-1:0] ask_mem [LEVELS];
  logic [QTY_WIDTH-1:0] bid_rd;
  logic [QTY_WIDTH-1:0] ask_rd;

  logic                 exec_apply;
  logic                 bid_we;
  logic                 ask_we;
  logic [IDX_W-1:0]     wr_addr;
  logic [QTY_WIDTH-1:0] wr_data;
  logic                 was_used;
  logic                 now_used;

  assign clearing   = (state == S_CLEAR);
  assign pop        = (state == S_IDLE) && !qstat.empty;
  assign exec_apply = (state == S_EXEC) && (cur.status == ST_APPLIED);
  assign bid_we     = clearing || (exec_apply && !cur.ask);
  assign ask_we     = clearing || (exec_apply && cur.ask);
  assign wr_addr    = clearing ? clr_idx : cur.idx;
  assign wr_data    = clearing ? '0 : cur.qty;

  // read is issued from the queue head as it pops, data lands for S_EXEC
  always_ff @(posedge clk) begin
    if (bid_we) begin
      bid_mem[wr_addr] <= wr_data;
    end
    bid_rd <= bid_mem[head.idx];
  end

  always_ff @(posedge clk) begin
    if (ask_we) begin
      ask_mem[wr_addr] <= wr_data;
    end
    ask_rd <= ask_mem[head.idx];
  end

  always_comb begin
    was_used     = cur.ask ? (ask_rd != '0) : (bid_rd != '0);
    now_used     = (cur.qty != '0);
    bid_cnt_next = bid_cnt;
    ask_cnt_next = ask_cnt;
    if (exec_apply) begin
      if (was_used && !now_used) begin
        if (cur.ask) begin
          ask_cnt_next = ask_cnt - CNT_W'(1);
        end else begin
          bid_cnt_next = bid_cnt - CNT_W'(1);
        end
      end else if (!was_used && now_used) begin
        if (cur.ask) begin
          ask_cnt_next = ask_cnt + CNT_W'(1);
        end else begin
          bid_cnt_next = bid_cnt + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      bid_cnt <= '0;
      ask_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= (state == S_EXEC);
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (clr_idx == IDX_W'(LEVELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          bid_cnt <= bid_cnt_next;
          ask_cnt <= ask_cnt_next;
          state   <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (state == S_EXEC) begin
      result.update_status   <= cur.status;
      result.bid_levels_used <= sat_count(bid_cnt_next);
      result.ask_levels_used <= sat_count(ask_cnt_next);
      result.book_empty      <= (bid_cnt_next == '0) && (ask_cnt_next == '0);
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_EXEC) else $error("result without execution");
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE && !clearing) else $error("pop outside idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    bid_cnt <= CNT_W'(LEVELS) && ask_cnt <= CNT_W'(LEVELS))
    else $error("level count beyond store depth");
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> result.book_empty == (bid_cnt == '0 && ask_cnt == '0))
    else $error("empty flag disagrees with counts");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !done |=> $stable(bid_cnt) || $past(state) == S_EXEC)
    else $error("count moved without an update");

endmodule

/* sv/price_level_book_update_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_book_update_top
// Dense bid/ask price level book with running non-zero level counts.
// ----------------------------------------------------------------------------
// After reset the block sweeps both level stores to zero, one level per cycle,
// holding busy high throughout; configuration writes are taken meanwhile.
// An update is taken when start is high and busy is low, and its result shows
// up on result for exactly one cycle with done high, having passed the queue,
// the S_EXEC state and the result register. In the back end an update takes a
// store read as it pops, then the compare-write and count update in S_EXEC,
// and no new update pops before it is through with the last; a four-entry
// queue lets up to seven updates be taken back to back into an idle block before
// busy rises. The receiver must take every result in the cycle it is shown.
module price_level_book_update_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  plbu_pkg::plbu_in_t                item,
  output logic                              done,
  output plbu_pkg::plbu_out_t               result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [plbu_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [plbu_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [plbu_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import plbu_pkg::*;

  logic [PRICE_W-1:0] lowest_price_tick;
  logic [PRICE_W-1:0] highest_price_tick;
  logic               cfg_wr;
  logic               accept;
  logic               push;
  logic               pop;
  logic               clearing;
  plbu_cmd_t          push_cmd;
  plbu_cmd_t          head;
  plbu_qstat_t        qstat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_price_tick  <= LOWEST_RESET;
      highest_price_tick <= HIGHEST_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3])
        REG_LOWEST:  lowest_price_tick  <= pwdata[PRICE_W-1:0];
        REG_HIGHEST: highest_price_tick <= pwdata[PRICE_W-1:0];
        default:     lowest_price_tick  <= lowest_price_tick;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_LOWEST:  prdata = CFG_DATA_W'(lowest_price_tick);
      REG_HIGHEST: prdata = CFG_DATA_W'(highest_price_tick);
      default:     prdata = '0;
    endcase
  end

  assign busy   = clearing || qstat.full;
  assign accept = start && !busy;

  plbu_front u_front (
    .accept             (accept),
    .item               (item),
    .lowest_price_tick  (lowest_price_tick),
    .highest_price_tick (highest_price_tick),
    .push               (push),
    .cmd                (push_cmd)
  );

  plbu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  plbu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the price level book update block: directed table
// of updates and range writes, then randomized phases over several price
// windows, each result checked field by field against its typed-in value or a local book model.
// ----------------------------------------------------------------------------
module tb_top;
  import plbu_pkg::*;

  typedef enum logic {
    ROW_UPDATE,
    ROW_WRITE
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic               reg_sel;
    logic [PRICE_W-1:0] reg_value;
    plbu_in_t           upd;
    bit                 typed;
    plbu_out_t          want;
  } dir_row_t;

  localparam int PHASES = 7;
  localparam int COUNT_TOP = (1 << CNT_OUT_W) - 1;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  plbu_in_t              item;
  logic                  done;
  plbu_out_t             result;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // sidecar for directed rows whose result is typed in
  bit                    item_typed;
  plbu_out_t             item_want;

  // local copy of the book and the price window
  logic [QTY_WIDTH-1:0]  level_qty [2][LEVELS];
  int                    levels_used [2];
  logic [PRICE_W-1:0]    cfg_lowest;
  logic [PRICE_W-1:0]    cfg_highest;

  plbu_out_t             book_expected [$];
  dir_row_t              directed_rows [$];
  int                    mismatches = 0;
  bit                    steady = 0;

  logic [PRICE_W-1:0] phase_lo [PHASES] = '{
    40'h0, 40'hFF_FFFF_F000, 40'h55_AAAA_5555, 40'd1000, 40'd700, 40'h0,
    40'h80_0000_0000};
  logic [PRICE_W-1:0] phase_hi [PHASES] = '{
    40'd4095, 40'hFF_FFFF_FFFF, 40'h55_AAAA_55EB, 40'hFF_FFFF_FFFF, 40'd699, 40'h0,
    40'h80_0000_0FFF};
  int phase_items [PHASES] = '{260, 230, 200, 230, 80, 80, 270};

  price_level_book_update_top u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(3_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [CNT_OUT_W-1:0] count_out(input int n);
    return (n > COUNT_TOP) ? CNT_OUT_W'(COUNT_TOP) : CNT_OUT_W'(n);
  endfunction

  // applies one update to the local book and returns the result it should give
  function automatic plbu_out_t book_apply(input plbu_in_t u);
    plbu_out_t            r;
    logic [PRICE_W-1:0]   off;
    logic [QTY_WIDTH-1:0] q;
    int                   s;
    off = u.price_tick - cfg_lowest;
    q = QTY_WIDTH'(u.level_quantity);
    if (u.price_tick < cfg_lowest || u.price_tick > cfg_highest ||
        off >= PRICE_W'(LEVELS)) begin
      r.update_status = ST_RANGE;
    end else if (u.book_side == SIDE_BID || u.book_side == SIDE_ASK) begin
      s = (u.book_side == SIDE_ASK) ? 1 : 0;
      if (level_qty[s][off[IDX_W-1:0]] != '0 && q == '0) begin
        levels_used[s]--;
      end else if (level_qty[s][off[IDX_W-1:0]] == '0 && q != '0) begin
        levels_used[s]++;
      end
      level_qty[s][off[IDX_W-1:0]] = q;
      r.update_status = ST_APPLIED;
    end else begin
      r.update_status = ST_SIDE;
    end
    r.bid_levels_used = count_out(levels_used[0]);
    r.ask_levels_used = count_out(levels_used[1]);
    r.book_empty = (levels_used[0] == 0 && levels_used[1] == 0);
    return r;
  endfunction

  function automatic plbu_in_t make_random_update();
    plbu_in_t        u;
    longint unsigned lo, hi, span, price;
    int              pick;
    lo = 64'(cfg_lowest);
    hi = 64'(cfg_highest);
    span = (hi >= lo) ? ((hi - lo > LEVELS - 1) ? LEVELS - 1 : hi - lo) : LEVELS - 1;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // half the in-window traffic hits a few hot levels so they get overwritten
      if ($urandom_range(0, 1) == 1) begin
        price = lo + $urandom_range(0, (span > 31) ? 31 : span);
      end else begin
        price = lo + $urandom_range(0, span);
      end
    end else if (pick < 85) begin
      case ($urandom_range(0, 4))
        0: price = lo - 1;
        1: price = hi + 1;
        2: price = lo + LEVELS;
        3: price = lo;
        default: price = hi;
      endcase
    end else begin
      price = (longint'($urandom_range(0, 255)) << 32) | longint'($urandom);
    end
    u.price_tick = PRICE_W'(price);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      u.book_side = SIDE_BID;
    end else if (pick < 90) begin
      u.book_side = SIDE_ASK;
    end else begin
      u.book_side = 2'($urandom_range(2, 3));
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      u.level_quantity = '0;
    end else if (pick < 50) begin
      u.level_quantity = IN_QTY_W'($urandom_range(1, 1 << 24));
    end else begin
      u.level_quantity = IN_QTY_W'({$urandom, $urandom});
    end
    return u;
  endfunction

  function automatic void add_update(input logic [1:0] side, input logic [PRICE_W-1:0] price,
                                     input logic [IN_QTY_W-1:0] qty, input bit typed = 0,
                                     input plbu_status_t st = ST_APPLIED, input int bids = 0,
                                     input int asks = 0, input logic empty = 1'b0);
    dir_row_t row;
    row.kind = ROW_UPDATE;
    row.reg_sel = REG_LOWEST;
    row.reg_value = '0;
    row.upd = '{book_side: side, price_tick: price, level_quantity: qty};
    row.typed = typed;
    row.want = '{update_status: st, bid_levels_used: CNT_OUT_W'(bids),
                 ask_levels_used: CNT_OUT_W'(asks), book_empty: empty};
    directed_rows = {directed_rows, row};
  endfunction

  function automatic void add_write(input logic sel, input logic [PRICE_W-1:0] value);
    dir_row_t row;
    row.kind = ROW_WRITE;
    row.reg_sel = sel;
    row.reg_value = value;
    row.upd = '0;
    row.typed = 0;
    row.want = '0;
    directed_rows = {directed_rows, row};
  endfunction

  task automatic note_mismatch(input string field, input longint unsigned got,
                               input longint unsigned want);
    if (mismatches < 100) begin
      $display("%0t: %s mismatch: got %0h, want %0h", $time, field, got, want);
    end
    mismatches++;
  endtask

  task automatic send_update(input plbu_in_t u, input bit typed, input plbu_out_t want);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < 31) begin
      gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= u;
    item_typed <= typed;
    item_want <= want;
    do @(posedge clk); while (busy);
  endtask

  // block goes idle: no update offered and every result back
  task automatic settle();
    start <= 1'b0;
    while (book_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [PRICE_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({sel, 3'b000});
    pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_LOWEST) begin
      cfg_lowest = value;
    end else begin
      cfg_highest = value;
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin : watch_results
    plbu_out_t want_res;
    if (!rst) begin
      if (done) begin
        if (book_expected.size() == 0) begin
          note_mismatch("result with nothing outstanding", 64'(result), '0);
        end else begin
          want_res = book_expected.pop_front();
          if (result.update_status != want_res.update_status) begin
            note_mismatch("update_status", 64'(result.update_status),
                          64'(want_res.update_status));
          end
          if (result.bid_levels_used != want_res.bid_levels_used) begin
            note_mismatch("bid_levels_used", 64'(result.bid_levels_used),
                          64'(want_res.bid_levels_used));
          end
          if (result.ask_levels_used != want_res.ask_levels_used) begin
            note_mismatch("ask_levels_used", 64'(result.ask_levels_used),
                          64'(want_res.ask_levels_used));
          end
          if (result.book_empty != want_res.book_empty) begin
            note_mismatch("book_empty", 64'(result.book_empty), 64'(want_res.book_empty));
          end
        end
      end
      // every accepted transfer runs through the model, typed rows included
      if (start && !busy) begin
        want_res = book_apply(item);
        if (item_typed) begin
          want_res = item_want;
        end
        book_expected = {book_expected, want_res};
      end
    end
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    item_typed <= 1'b0;
    item_want <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    foreach (level_qty[s, i]) level_qty[s][i] = '0;
    levels_used[0] = 0;
    levels_used[1] = 0;
    cfg_lowest = LOWEST_RESET;
    cfg_highest = HIGHEST_RESET;

    // reset window 0..4095, empty book
    add_update(SIDE_BID, 40'd0, 48'hFFFF_FFFF_FFFF, 1, ST_APPLIED, 1, 0, 1'b0);
    add_update(SIDE_ASK, 40'd4095, 48'd1, 1, ST_APPLIED, 1, 1, 1'b0);
    add_update(SIDE_BID, 40'd4096, 48'd5, 1, ST_RANGE, 1, 1, 1'b0);
    add_update(SIDE_ASK, 40'hFF_FFFF_FFFF, 48'd7, 1, ST_RANGE, 1, 1, 1'b0);
    add_update(2'd2, 40'd10, 48'd3, 1, ST_SIDE, 1, 1, 1'b0);
    add_update(2'd3, 40'd4095, 48'd0, 1, ST_SIDE, 1, 1, 1'b0);
    add_update(2'd3, 40'd4096, 48'd2, 1, ST_RANGE, 1, 1, 1'b0);
    add_update(SIDE_BID, 40'd0, 48'd0, 1, ST_APPLIED, 0, 1, 1'b0);
    add_update(SIDE_ASK, 40'd4095, 48'd0, 1, ST_APPLIED, 0, 0, 1'b1);
    add_update(SIDE_BID, 40'd100, 48'd0, 1, ST_APPLIED, 0, 0, 1'b1);
    add_update(SIDE_BID, 40'd100, 48'd9, 1, ST_APPLIED, 1, 0, 1'b0);
    add_update(SIDE_BID, 40'd100, 48'd12, 1, ST_APPLIED, 1, 0, 1'b0);
    add_update(SIDE_ASK, 40'd100, 48'h8000_0000_0000, 1, ST_APPLIED, 1, 1, 1'b0);
    add_update(SIDE_BID, 40'd100, 48'd0, 1, ST_APPLIED, 0, 1, 1'b0);
    add_update(SIDE_ASK, 40'd100, 48'd0, 1, ST_APPLIED, 0, 0, 1'b1);
    add_update(SIDE_BID, 40'd2047, 48'h0000_0100_0000);
    add_update(SIDE_ASK, 40'd1, 48'h7FFF_FFFF_FFFF);
    // window wider than the store: index limit decides
    add_write(REG_HIGHEST, 40'hFF_FFFF_FFFF);
    add_update(SIDE_BID, 40'd4096, 48'd1, 1, ST_RANGE, 1, 1, 1'b0);
    add_write(REG_LOWEST, 40'hFF_FFFF_F000);
    add_update(SIDE_BID, 40'hFF_FFFF_FFFF, 48'd2, 1, ST_APPLIED, 2, 1, 1'b0);
    add_update(SIDE_ASK, 40'hFF_FFFF_EFFF, 48'd3, 1, ST_RANGE, 2, 1, 1'b0);
    add_update(SIDE_BID, 40'hFF_FFFF_F000, 48'd0, 1, ST_APPLIED, 2, 1, 1'b0);
    // lowest above highest closes the book to every price
    add_write(REG_LOWEST, 40'd10);
    add_write(REG_HIGHEST, 40'd9);
    add_update(SIDE_BID, 40'd10, 48'd4, 1, ST_RANGE, 2, 1, 1'b0);
    add_update(SIDE_ASK, 40'd9, 48'd4, 1, ST_RANGE, 2, 1, 1'b0);
    add_update(2'd2, 40'd10, 48'd4, 1, ST_RANGE, 2, 1, 1'b0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        settle();
        write_reg(directed_rows[r].reg_sel, directed_rows[r].reg_value);
      end else begin
        send_update(directed_rows[r].upd, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_LOWEST, phase_lo[p]);
      write_reg(REG_HIGHEST, phase_hi[p]);
      steady = (p == PHASES - 1);
      repeat (phase_items[p]) send_update(make_random_update(), 1'b0, '0);
    end

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/plbu_pkg.sv
sv/plbu_front.sv
sv/plbu_queue.sv
sv/plbu_back.sv
sv/price_level_book_update_top.sv
tb/sv/tb_top.sv
